>>> rtl/core/pte_pkg.sv
// Shared types, constants and the sine table for the procedural texture evaluator.
package pte_pkg;

  localparam int SINE_DEPTH    = 256;
  localparam int SINE_IDX_W    = $clog2(SINE_DEPTH);
  localparam int OCTAVE_COUNT  = 9;
  localparam int FRAC_W        = 24;
  localparam int PROD_KEEP_W   = FRAC_W + 14;
  localparam int ROT_SHIFT     = 14;
  localparam int SINE_W        = 17;
  localparam int PADDR_W       = 4;
  localparam int REG_IDX_W     = 2;
  localparam int PDATA_W       = 32;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  typedef enum logic [2:0] {
    MODE_SINE     = 3'd0,
    MODE_SINE_COS = 3'd1,
    MODE_STRIPES  = 3'd2,
    MODE_CHECKER  = 3'd3,
    MODE_WEIGHTED = 3'd4
  } mode_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MODE  = 2'd0,
    REG_COS   = 2'd1,
    REG_SIN   = 2'd2,
    REG_SCALE = 2'd3
  } reg_idx_e;

  localparam logic [2:0]         RESET_MODE  = MODE_CHECKER;
  localparam logic signed [15:0] RESET_COS   = 16'sd16384;
  localparam logic signed [15:0] RESET_SIN   = 16'sd0;
  localparam logic [15:0]        RESET_SCALE = 16'd256;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [15:0] cos;
    logic signed [15:0] sin;
    logic [15:0]        scale;
  } cfg_t;

  typedef logic [SINE_DEPTH-1:0][SINE_W-1:0] sine_tab_t;

  function automatic logic [63:0] quarter_sine(input logic [63:0] m);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    x  = (m * HALF_PI_Q30) / 64'(SINE_DEPTH);
    x2 = (x * x) >> 30;
    t  = ONE_Q30 - x2 / 64'd110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    return (x * t) >> 30;
  endfunction

  function automatic logic [SINE_W-1:0] sine_entry(input logic [63:0] i);
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] m;
    logic [63:0] v;
    q = (64'd4 * i) / 64'(SINE_DEPTH);
    r = 64'd4 * i - q * 64'(SINE_DEPTH);
    m = q[0] ? 64'(SINE_DEPTH) - r : r;
    v = (quarter_sine(m) + 64'd16384) >> 15;
    return q[1] ? SINE_W'(64'd0 - v) : SINE_W'(v);
  endfunction

  function automatic sine_tab_t build_sine_table();
    sine_tab_t tab;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      tab[i] = sine_entry(64'(i));
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TABLE = build_sine_table();

endpackage

>>> rtl/core/pte_cfg_regs.sv
// Configuration register file behind the APB-style port.
module pte_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pte_pkg::PADDR_W-1:0]  paddr,
  input  logic [pte_pkg::PDATA_W-1:0]  pwdata,
  output logic [pte_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output pte_pkg::cfg_t                cfg_o
);

  pte_pkg::cfg_t                      cfg_q;
  logic                               wr_en;
  logic [pte_pkg::REG_IDX_W-1:0]      reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[pte_pkg::PADDR_W-1:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode  <= pte_pkg::RESET_MODE;
      cfg_q.cos   <= pte_pkg::RESET_COS;
      cfg_q.sin   <= pte_pkg::RESET_SIN;
      cfg_q.scale <= pte_pkg::RESET_SCALE;
    end else if (wr_en) begin
      unique case (reg_idx)
        pte_pkg::REG_MODE:  cfg_q.mode  <= pwdata[2:0];
        pte_pkg::REG_COS:   cfg_q.cos   <= pwdata[15:0];
        pte_pkg::REG_SIN:   cfg_q.sin   <= pwdata[15:0];
        pte_pkg::REG_SCALE: cfg_q.scale <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pte_pkg::REG_MODE:  prdata = {29'd0, cfg_q.mode};
      pte_pkg::REG_COS:   prdata = {16'd0, cfg_q.cos};
      pte_pkg::REG_SIN:   prdata = {16'd0, cfg_q.sin};
      pte_pkg::REG_SCALE: prdata = {16'd0, cfg_q.scale};
      default:            prdata = '0;
    endcase
  end

endmodule

>>> rtl/core/pte_rotate.sv
// Rotation and scaling stages: products, rotated sums, scaled phase fractions.
module pte_rotate (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pte_pkg::cfg_t                cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [31:0]           coord_x_i,
  input  logic signed [31:0]           coord_y_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [pte_pkg::FRAC_W-1:0]   px_o,
  output logic [pte_pkg::FRAC_W-1:0]   py_o
);

  localparam int KW = pte_pkg::PROD_KEEP_W;
  localparam int FW = pte_pkg::FRAC_W;

  logic                 v1_q, v2_q, v3_q;
  logic                 adv1, adv2, adv3;
  logic signed [47:0]   cx, sy, sx, cy;
  logic [KW-1:0]        cx_q, sy_q, sx_q, cy_q;
  logic [KW-1:0]        rx_sum, ry_sum;
  logic [FW-1:0]        rx_q, ry_q;
  logic [FW+15:0]       px_full, py_full;
  logic [FW-1:0]        px_q, py_q;

  assign adv3       = !v3_q || ready_i;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_stall_o = !adv1;

  assign cx = cfg_i.cos * coord_x_i;
  assign sy = cfg_i.sin * coord_y_i;
  assign sx = cfg_i.sin * coord_x_i;
  assign cy = cfg_i.cos * coord_y_i;

  assign rx_sum = cx_q - sy_q;
  assign ry_sum = sx_q + cy_q;

  assign px_full = {16'd0, rx_q} * {FW'(0), cfg_i.scale};
  assign py_full = {16'd0, ry_q} * {FW'(0), cfg_i.scale};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= in_valid_i;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      cx_q <= cx[KW-1:0];
      sy_q <= sy[KW-1:0];
      sx_q <= sx[KW-1:0];
      cy_q <= cy[KW-1:0];
    end
    if (adv2 && v1_q) begin
      rx_q <= rx_sum[KW-1:pte_pkg::ROT_SHIFT];
      ry_q <= ry_sum[KW-1:pte_pkg::ROT_SHIFT];
    end
    if (adv3 && v2_q) begin
      px_q <= px_full[FW-1:0];
      py_q <= py_full[FW-1:0];
    end
  end

  assign valid_o = v3_q;
  assign px_o    = px_q;
  assign py_o    = py_q;

endmodule

>>> rtl/core/pte_pattern.sv
// Pattern stages: table lookups and checker bits, then mode select and output register.
module pte_pattern (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pte_pkg::cfg_t                cfg_i,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [pte_pkg::FRAC_W-1:0]   px_i,
  input  logic [pte_pkg::FRAC_W-1:0]   py_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [15:0]                  texture_value_o
);

  localparam int FW  = pte_pkg::FRAC_W;
  localparam int IW  = pte_pkg::SINE_IDX_W;
  localparam int SW  = pte_pkg::SINE_W;
  localparam int OC  = pte_pkg::OCTAVE_COUNT;
  localparam int KW  = 5;
  localparam logic [IW:0] DEPTH_W   = (IW+1)'(pte_pkg::SINE_DEPTH);
  localparam logic [IW:0] QUARTER_W = (IW+1)'(pte_pkg::SINE_DEPTH / 4);

  logic                   v4_q, v5_q;
  logic                   adv4, adv5;
  logic [FW+IW-1:0]       sin_prod, cos_prod;
  logic [IW-1:0]          sin_idx, cos_base;
  logic [IW:0]            cos_sum;
  logic [IW-1:0]          cos_idx;
  logic [OC-1:0]          oct_bits;
  logic [FW+KW-1:0]       qx [OC];
  logic [FW+KW-1:0]       qy [OC];
  logic signed [SW-1:0]   sv_q, cv_q;
  logic                   hx_q, hy_q;
  logic [OC-1:0]          oct_q;
  logic signed [2*SW-1:0] sc_prod;
  logic signed [2*SW:0]   sc_sum;
  logic signed [SW:0]     s_sum;
  logic [16:0]            val;
  logic [15:0]            val_sat;
  logic [15:0]            value_q;

  assign adv5    = !v5_q || !out_stall_i;
  assign adv4    = !v4_q || adv5;
  assign ready_o = adv4;

  assign sin_prod = {IW'(0), px_i} * (FW+IW)'(pte_pkg::SINE_DEPTH);
  assign cos_prod = {IW'(0), py_i} * (FW+IW)'(pte_pkg::SINE_DEPTH);
  assign sin_idx  = sin_prod[FW +: IW];
  assign cos_base = cos_prod[FW +: IW];
  assign cos_sum  = {1'b0, cos_base} + QUARTER_W;

  always_comb begin
    if (cos_sum >= DEPTH_W) begin
      cos_idx = IW'(cos_sum - DEPTH_W);
    end else begin
      cos_idx = cos_sum[IW-1:0];
    end
  end

  always_comb begin
    for (int k = 0; k < OC; k++) begin
      qx[k]       = {KW'(0), px_i} * (FW+KW)'(k + 1);
      qy[k]       = {KW'(0), py_i} * (FW+KW)'(k + 1);
      oct_bits[k] = qx[k][FW-1] ^ qy[k][FW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (adv4) begin
        v4_q <= valid_i;
      end
      if (adv5) begin
        v5_q <= v4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv4 && valid_i) begin
      sv_q  <= pte_pkg::SINE_TABLE[sin_idx];
      cv_q  <= pte_pkg::SINE_TABLE[cos_idx];
      hx_q  <= px_i[FW-1];
      hy_q  <= py_i[FW-1];
      oct_q <= oct_bits;
    end
    if (adv5 && v4_q) begin
      value_q <= val_sat;
    end
  end

  assign sc_prod = sv_q * cv_q;
  assign sc_sum  = (2*SW+1)'(sc_prod) + (2*SW+1)'(pte_pkg::ONE_Q30);
  assign s_sum   = (SW+1)'(sv_q) + (SW+1)'(32768);

  always_comb begin
    val = '0;
    case (cfg_i.mode)
      pte_pkg::MODE_SINE:     val = s_sum[16:0];
      pte_pkg::MODE_SINE_COS: val = sc_sum[31:15];
      pte_pkg::MODE_STRIPES:  val = hx_q ? 17'd0 : 17'd65535;
      pte_pkg::MODE_CHECKER:  val = (hx_q != hy_q) ? 17'd65535 : 17'd0;
      pte_pkg::MODE_WEIGHTED: begin
        for (int k = 0; k < OC; k++) begin
          val[15-k] = oct_q[k];
        end
      end
      default:                val = '0;
    endcase
  end

  assign val_sat = val[16] ? 16'hFFFF : val[15:0];

  assign out_valid_o     = v5_q;
  assign texture_value_o = value_q;

endmodule

>>> rtl/core/procedural_texture_evaluator_core.sv
// Top level of the procedural texture evaluator: config registers and five-stage pipeline.
// Throughput: one request per cycle; a stalled stage holds, earlier bubbles still fill.
// Stages: products, rotated sums, scale multiply, table lookup, mode select and output.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
module procedural_texture_evaluator_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pte_pkg::PADDR_W-1:0]  paddr,
  input  logic [pte_pkg::PDATA_W-1:0]  pwdata,
  output logic [pte_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [31:0]           coord_x_i,
  input  logic signed [31:0]           coord_y_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [15:0]                  texture_value_o
);

  pte_pkg::cfg_t                      cfg;
  logic                               rot_valid;
  logic                               pat_ready;
  logic [pte_pkg::FRAC_W-1:0]         px;
  logic [pte_pkg::FRAC_W-1:0]         py;

  pte_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pte_rotate u_rotate (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .coord_x_i  (coord_x_i),
    .coord_y_i  (coord_y_i),
    .valid_o    (rot_valid),
    .ready_i    (pat_ready),
    .px_o       (px),
    .py_o       (py)
  );

  pte_pattern u_pattern (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .valid_i         (rot_valid),
    .ready_o         (pat_ready),
    .px_i            (px),
    .py_i            (py),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .texture_value_o (texture_value_o)
  );

endmodule
